// ===== hdl/baud_scale_step_search_assert.svh =====
// Assertion macros used by the baud divisor search block.
`ifndef BAUD_SCALE_STEP_SEARCH_ASSERT_SVH
`define BAUD_SCALE_STEP_SEARCH_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BSS_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("baud divisor search: assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define BSS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("baud divisor search: assertion failed");

`endif

// ===== hdl/bss_pkg.sv =====
package bss_pkg;

	// Search bounds.
	localparam int unsigned SCALE_LIMIT = 255;
	localparam int unsigned STEP_LIMIT  = 13107;

	// Field widths.
	localparam int unsigned BAUD_W    = 25;
	localparam int unsigned SCALE_W   = 8;
	localparam int unsigned STEP_W    = 14;
	localparam int unsigned CLK_W     = 32;
	localparam int unsigned FRAC_BITS = 17;

	// Derived widths of the datapath.
	localparam int unsigned PROD_W = BAUD_W + SCALE_W;        // baud * (scale + 1)
	localparam int unsigned NUM_W  = PROD_W + FRAC_BITS;      // divider dividend
	localparam int unsigned DIV_W  = CLK_W;                   // divider divisor
	localparam int unsigned MULX_W = CLK_W + STEP_W;          // clk * step
	localparam int unsigned GOT_W  = MULX_W + 1 - FRAC_BITS;  // achieved rate
	localparam int unsigned CNT_W  = $clog2(NUM_W + 1);

	localparam logic [CLK_W-1:0] CLK_RESET = CLK_W'(40000000);

	typedef enum logic [2:0] {
		S_IDLE,
		S_STEP_GO,
		S_STEP_WAIT,
		S_MUL,
		S_RATE_GO,
		S_RATE_WAIT,
		S_CMP,
		S_FINISH
	} bss_state_t;

	typedef struct packed {
		logic             start;
		logic [NUM_W-1:0] dividend;
		logic [DIV_W-1:0] divisor;
	} bss_div_req_t;

	typedef struct packed {
		logic             busy;
		logic             done;
		logic [NUM_W-1:0] quot;
	} bss_div_rsp_t;

endpackage

// ===== hdl/bss_in_if.sv =====
interface bss_in_if;
	logic                        valid;
	logic                        ready;
	logic [bss_pkg::BAUD_W-1:0]  requested_baud;

	modport source (output valid, output requested_baud, input ready);
	modport sink (input valid, input requested_baud, output ready);
endinterface

// ===== hdl/bss_out_if.sv =====
interface bss_out_if;
	logic                        valid;
	logic                        ready;
	logic [bss_pkg::SCALE_W-1:0] best_scale;
	logic [bss_pkg::STEP_W-1:0]  best_step;
	logic [bss_pkg::BAUD_W-1:0]  rate_error;

	modport source (output valid, output best_scale, output best_step, output rate_error,
		input ready);
	modport sink (input valid, input best_scale, input best_step, input rate_error,
		output ready);
endinterface

// ===== hdl/bss_div.sv =====
// Restoring divider, one quotient bit per cycle.
module bss_div (
	input  logic                  clk,
	input  logic                  arst_n,
	input  bss_pkg::bss_div_req_t req,
	output bss_pkg::bss_div_rsp_t rsp
);

	logic                         busy_q;
	logic                         done_q;
	logic [bss_pkg::CNT_W-1:0]    cnt_q;
	logic [bss_pkg::DIV_W-1:0]    rem_q;
	logic [bss_pkg::DIV_W-1:0]    dsr_q;
	logic [bss_pkg::NUM_W-1:0]    quo_q;
	logic [bss_pkg::DIV_W:0]      trial;
	logic [bss_pkg::DIV_W:0]      diff;
	logic                         fits;

	assign trial = {rem_q, quo_q[bss_pkg::NUM_W-1]};
	assign diff  = trial - {1'b0, dsr_q};
	assign fits  = (trial >= {1'b0, dsr_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= bss_pkg::CNT_W'(bss_pkg::NUM_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - bss_pkg::CNT_W'(1);
				if (cnt_q == bss_pkg::CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= '0;
			dsr_q <= req.divisor;
			quo_q <= req.dividend;
		end else if (busy_q) begin
			rem_q <= fits ? diff[bss_pkg::DIV_W-1:0] : trial[bss_pkg::DIV_W-1:0];
			quo_q <= {quo_q[bss_pkg::NUM_W-2:0], fits};
		end
	end

	assign rsp.busy = busy_q;
	assign rsp.done = done_q;
	assign rsp.quot = quo_q;

endmodule

// ===== hdl/baud_scale_step_search.sv =====
// Fractional baud divisor search. A transaction on the input channel carries a requested
// baud rate; the block tries every prescale value from 0 upward, derives the step as
// floor(baud * (scale + 1) * 2^17 / clk), stops at the first step above the step limit,
// and returns one transaction with the prescale and step whose achieved rate
// round(clk * step / (2^17 * (scale + 1))) is closest to the request (the lower
// prescale wins a tie), plus the absolute rate error. The UART reference clock is
// taken from the configuration register, which resets to 40 MHz and must only be
// written while the block is idle. A request tries at most the full range of 255
// prescale values, and none when the reference clock register is zero. Each trial
// runs the single shared restoring divider twice. Input ready is high only while no
// request is being searched; a finished result waits in an output register, so a new
// request can be taken while the last result is unread.
module baud_scale_step_search (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_wr_en,
	input  logic [bss_pkg::CLK_W-1:0]  cfg_wr_data,
	bss_in_if.sink                     in_ch,
	bss_out_if.source                  out_ch
);

`include "baud_scale_step_search_assert.svh"

	bss_pkg::bss_state_t state_q, state_d;

	// Configuration register holding the UART reference clock in hertz.
	logic [bss_pkg::CLK_W-1:0]    uart_clk_q;

	// Working registers of the current search.
	logic [bss_pkg::BAUD_W-1:0]   baud_q;
	logic [bss_pkg::PROD_W-1:0]   prod_q;     // baud * (scale + 1), built by adding
	logic [bss_pkg::SCALE_W-1:0]  scale_q;
	logic [bss_pkg::STEP_W-1:0]   step_q;
	logic [bss_pkg::MULX_W-1:0]   mulx_q;     // clk * step
	logic [bss_pkg::GOT_W-1:0]    got_q;      // achieved rate of this trial

	// Best candidate so far.
	logic [bss_pkg::SCALE_W-1:0]  best_scale_q;
	logic [bss_pkg::STEP_W-1:0]   best_step_q;
	logic [bss_pkg::BAUD_W-1:0]   best_err_q;

	// Output register.
	logic                         out_valid_q;
	logic [bss_pkg::SCALE_W-1:0]  out_scale_q;
	logic [bss_pkg::STEP_W-1:0]   out_step_q;
	logic [bss_pkg::BAUD_W-1:0]   out_err_q;

	bss_pkg::bss_div_req_t        div_req;
	bss_pkg::bss_div_rsp_t        div_rsp;

	logic                         in_fire;
	logic                         slot_free;
	logic                         step_over;
	logic                         last_scale;
	logic [bss_pkg::SCALE_W-1:0]  scale_inc;
	logic [bss_pkg::MULX_W:0]     rate_num;
	logic [bss_pkg::GOT_W-1:0]    err;
	logic                         better;

	bss_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	assign in_ch.ready = (state_q == bss_pkg::S_IDLE);
	assign in_fire     = in_ch.valid && in_ch.ready;
	assign slot_free   = !out_valid_q || out_ch.ready;

	// No trial uses a scale above SCALE_LIMIT - 1, so the divisor scale + 1 fits in SCALE_W bits.
	assign scale_inc  = scale_q + bss_pkg::SCALE_W'(1);
	assign last_scale = (scale_q == bss_pkg::SCALE_W'(bss_pkg::SCALE_LIMIT - 1));
	assign step_over  = (div_rsp.quot > bss_pkg::NUM_W'(bss_pkg::STEP_LIMIT));

	// Rounding half up: add half the divider, then the divide by 2^17 is a shift and the
	// remaining divide by (scale + 1) goes to the shared divider.
	assign rate_num = {1'b0, mulx_q}
		+ (bss_pkg::MULX_W + 1)'({scale_inc, (bss_pkg::FRAC_BITS - 1)'(0)});

	assign err    = (got_q >= bss_pkg::GOT_W'(baud_q)) ? (got_q - bss_pkg::GOT_W'(baud_q))
		: (bss_pkg::GOT_W'(baud_q) - got_q);
	assign better = (err < bss_pkg::GOT_W'(best_err_q));

	// Divider requests: the step division in STEP_GO, the rate division in RATE_GO.
	always_comb begin
		div_req.start    = 1'b0;
		div_req.dividend = {prod_q, bss_pkg::FRAC_BITS'(0)};
		div_req.divisor  = uart_clk_q;
		if (state_q == bss_pkg::S_STEP_GO) begin
			div_req.start = 1'b1;
		end else if (state_q == bss_pkg::S_RATE_GO) begin
			div_req.start    = 1'b1;
			div_req.dividend = bss_pkg::NUM_W'(rate_num[bss_pkg::MULX_W:bss_pkg::FRAC_BITS]);
			div_req.divisor  = bss_pkg::DIV_W'(scale_inc);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= bss_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			bss_pkg::S_IDLE: begin
				// A zero reference clock allows no trial at all.
				if (in_fire) begin
					state_d = (uart_clk_q == '0) ? bss_pkg::S_FINISH : bss_pkg::S_STEP_GO;
				end
			end
			bss_pkg::S_STEP_GO: begin
				state_d = bss_pkg::S_STEP_WAIT;
			end
			bss_pkg::S_STEP_WAIT: begin
				if (div_rsp.done) begin
					state_d = step_over ? bss_pkg::S_FINISH : bss_pkg::S_MUL;
				end
			end
			bss_pkg::S_MUL: begin
				state_d = bss_pkg::S_RATE_GO;
			end
			bss_pkg::S_RATE_GO: begin
				state_d = bss_pkg::S_RATE_WAIT;
			end
			bss_pkg::S_RATE_WAIT: begin
				if (div_rsp.done) begin
					state_d = bss_pkg::S_CMP;
				end
			end
			bss_pkg::S_CMP: begin
				state_d = last_scale ? bss_pkg::S_FINISH : bss_pkg::S_STEP_GO;
			end
			bss_pkg::S_FINISH: begin
				if (slot_free) begin
					state_d = bss_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = bss_pkg::S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			uart_clk_q  <= bss_pkg::CLK_RESET;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				uart_clk_q <= cfg_wr_data;
			end
			if (state_q == bss_pkg::S_FINISH && slot_free) begin
				out_valid_q <= 1'b1;
			end else if (out_ch.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Datapath registers, loaded under the sequencer.
	always_ff @(posedge clk) begin
		if (in_fire) begin
			baud_q       <= in_ch.requested_baud;
			prod_q       <= bss_pkg::PROD_W'(in_ch.requested_baud);
			scale_q      <= '0;
			best_scale_q <= '0;
			best_step_q  <= '0;
			best_err_q   <= in_ch.requested_baud;
		end
		if (state_q == bss_pkg::S_STEP_WAIT && div_rsp.done) begin
			step_q <= div_rsp.quot[bss_pkg::STEP_W-1:0];
		end
		if (state_q == bss_pkg::S_MUL) begin
			mulx_q <= bss_pkg::MULX_W'(uart_clk_q) * bss_pkg::MULX_W'(step_q);
		end
		if (state_q == bss_pkg::S_RATE_WAIT && div_rsp.done) begin
			got_q <= div_rsp.quot[bss_pkg::GOT_W-1:0];
		end
		if (state_q == bss_pkg::S_CMP) begin
			if (better) begin
				best_err_q   <= err[bss_pkg::BAUD_W-1:0];
				best_scale_q <= scale_q;
				best_step_q  <= step_q;
			end
			scale_q <= scale_inc;
			prod_q  <= prod_q + bss_pkg::PROD_W'(baud_q);
		end
		if (state_q == bss_pkg::S_FINISH && slot_free) begin
			out_scale_q <= best_scale_q;
			out_step_q  <= best_step_q;
			out_err_q   <= best_err_q;
		end
	end

	assign out_ch.valid      = out_valid_q;
	assign out_ch.best_scale = out_scale_q;
	assign out_ch.best_step  = out_step_q;
	assign out_ch.rate_error = out_err_q;

	// The divider is only started when it is free.
	`BSS_ASSERT_IMP(a_div_start_free, clk, arst_n, div_req.start, !div_rsp.busy)
	// A divider completion is only seen while the sequencer waits for it.
	`BSS_ASSERT_IMP(a_div_done_wait, clk, arst_n, div_rsp.done,
		(state_q == bss_pkg::S_STEP_WAIT) || (state_q == bss_pkg::S_RATE_WAIT))
	// The kept error never exceeds the starting error of the request.
	`BSS_ASSERT_IMP(a_err_bound, clk, arst_n, state_q == bss_pkg::S_FINISH,
		best_err_q <= baud_q)
	// A result that is loaded holds a step inside the search bound.
	`BSS_ASSERT_NEXT(a_step_bound, clk, arst_n,
		(state_q == bss_pkg::S_FINISH) && slot_free,
		out_valid_q && (out_step_q <= bss_pkg::STEP_W'(bss_pkg::STEP_LIMIT)))

endmodule

// ===== tb/tb_top.sv =====
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import bss_pkg::*;

	// The largest baud in the documented range, and the largest the field can carry.
	localparam int unsigned BAUD_TOP  = 30_000_000;
	localparam int unsigned BAUD_FULL = (1 << BAUD_W) - 1;

	// A full search tries all 255 prescale values, and the run has 121 requests. The limit
	// assumes that every one of them is a full search with the longest stalls, and then
	// allows for that several times over.
	localparam int unsigned CYCLE_LIMIT = 20_000_000;

	// After the last result has arrived, this many cycles pass before the verdict.
	// A spurious extra transaction would show up in that window.
	localparam int unsigned TAIL_CYCLES = 300;

	localparam longint unsigned FRAC_ONE = 64'd1 << FRAC_BITS;

	// One expected result: the divisor pair that the search should settle on.
	typedef struct packed {
		logic [SCALE_W-1:0] scale;
		logic [STEP_W-1:0]  step;
		logic [BAUD_W-1:0]  err;
	} divisor_t;

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_wr_en;
	logic [CLK_W-1:0] cfg_wr_data;

	bss_in_if  in_ch();
	bss_out_if out_ch();

	baud_scale_step_search dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.in_ch       (in_ch),
		.out_ch      (out_ch)
	);

	always #2 clk = ~clk;

	// Our copy of the reference clock register. It follows every write we make.
	logic [CLK_W-1:0] uart_clk_hz = CLK_RESET;

	// Divisor pairs predicted for the requests already accepted, oldest first.
	divisor_t pending_divisors[$];

	int unsigned mismatches = 0;

	// Both sides idle at random while this is set. The last test clears it.
	bit idle_on = 1'b1;

	// Predict the search. It steps through the prescale values from zero upward, and each
	// trial derives the largest step whose unrounded rate does not exceed the request.
	// A trial whose step passes the step limit ends the search. A candidate replaces
	// the kept pair only when its error is strictly smaller, so on a tie the lower
	// prescale stays. With no reference clock there is nothing to try at all.
	function automatic divisor_t search_divisor(input logic [CLK_W-1:0] hz,
			input logic [BAUD_W-1:0] baud);
		longint unsigned ref_hz, want_baud, step, div, rate, diff, best_err;
		divisor_t best;
		ref_hz = 64'(hz);
		want_baud = 64'(baud);
		best = '0;
		best_err = want_baud;
		if (ref_hz != 0) begin
			for (int unsigned s = 0; s < SCALE_LIMIT; s++) begin
				step = (want_baud * 64'(s + 1) * FRAC_ONE) / ref_hz;
				if (step > 64'(STEP_LIMIT))
					break;
				div = FRAC_ONE * 64'(s + 1);
				// The achieved rate is rounded half up.
				rate = (ref_hz * step + div / 2) / div;
				diff = (rate >= want_baud) ? rate - want_baud : want_baud - rate;
				if (diff < best_err) begin
					best_err = diff;
					best.scale = SCALE_W'(s);
					best.step = STEP_W'(step);
				end
			end
		end
		best.err = BAUD_W'(best_err);
		return best;
	endfunction

	// Choose a random request. Most requests sit where the search runs for a few
	// dozen trials at the current clock, which is where the choice between prescale
	// values gets interesting. The rest either span the whole field, which mostly
	// ends the search at once, or come from a random bit length, which at fast
	// clocks means full searches.
	function automatic logic [BAUD_W-1:0] pick_baud(input logic [CLK_W-1:0] hz);
		longint unsigned near;
		int unsigned kind, bits;
		kind = $urandom_range(0, 99);
		bits = $urandom_range(1, BAUD_W);
		near = 64'(hz) / 64'(10 * $urandom_range(1, 48));
		if (near <= 64'(BAUD_TOP))
			near = near + 64'($urandom_range(0, 32'(near / 8)));
		if (kind < 60 && near <= 64'(BAUD_TOP))
			return BAUD_W'(near);
		if (kind < 85)
			return BAUD_W'($urandom_range(0, BAUD_FULL));
		return BAUD_W'($urandom) & BAUD_W'((64'd1 << bits) - 1);
	endfunction

	task automatic report_mismatch(input string msg);
		mismatches++;
		$display("mismatch at %0t ns: %s", $time, msg);
	endtask

	// Offer one request and wait for the transaction to be taken. The prediction is
	// queued at the very edge that accepts the request. Valid stays high on return;
	// the next request or the next drain decides what it does at the falling edge.
	task automatic send_baud(input logic [BAUD_W-1:0] baud);
		@(negedge clk);
		if (idle_on && $urandom_range(0, 3) == 0) begin
			in_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 10)) @(negedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.requested_baud <= baud;
		do @(posedge clk); while (!in_ch.ready);
		pending_divisors.push_back(search_divisor(uart_clk_hz, baud));
	endtask

	task automatic send_list(input logic [BAUD_W-1:0] bauds[$]);
		foreach (bauds[i])
			send_baud(bauds[i]);
	endtask

	task automatic send_random(input int unsigned count);
		repeat (count)
			send_baud(pick_baud(uart_clk_hz));
	endtask

	// Drop valid and wait until every accepted request has produced its result.
	// Each request yields exactly one result, so once the queue is empty the block
	// has nothing left in flight and the clock register may be written.
	task automatic drain();
		@(negedge clk);
		in_ch.valid <= 1'b0;
		while (pending_divisors.size() != 0)
			@(posedge clk);
	endtask

	// Write the reference clock register. This is only called after a drain.
	task automatic write_clock(input logic [CLK_W-1:0] hz);
		@(negedge clk);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= hz;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
		uart_clk_hz = hz;
	endtask

	// The register is left at its reset value of 40 MHz here. The list covers a zero
	// request, a request so small that no step beats the starting error, full
	// searches at 300 and 9600 baud, shorter ones at 115200 and 921600, the request that
	// lands exactly on the step limit, one just above it that stops the search at the
	// first trial, and the top of the range and of the field.
	task automatic test_reset_clock();
		send_list('{0, 1, 300, 9600, 115200, 921600, 3_000_000, 4_000_000, 4_000_300,
			BAUD_TOP, BAUD_FULL});
		send_random(20);
		drain();
	endtask

	// With no reference clock there is no trial, and every request comes back as
	// its own error with a zero pair.
	task automatic test_clock_zero();
		write_clock('0);
		send_list('{0, 115200, BAUD_FULL});
		drain();
	endtask

	// At one hertz every nonzero request overruns the step limit at once.
	task automatic test_clock_one();
		write_clock(CLK_W'(1));
		send_list('{0, 1, BAUD_FULL});
		send_random(5);
		drain();
	endtask

	// The fastest clock makes the products as wide as they can get and sends small
	// requests through all prescale values.
	task automatic test_clock_max();
		write_clock('1);
		send_list('{1, 115200, BAUD_TOP, BAUD_FULL});
		send_random(15);
		drain();
	endtask

	// Four phases at random clocks, each either anywhere in the register's range or
	// at a realistic UART clock, chosen at random.
	task automatic test_random_clocks();
		repeat (4) begin
			if ($urandom_range(0, 1) == 0)
				write_clock(CLK_W'($urandom));
			else
				write_clock(CLK_W'($urandom_range(1_000_000, 200_000_000)));
			send_random(10);
			drain();
		end
	endtask

	// The final stretch runs back to back on both sides.
	task automatic test_no_idle();
		idle_on = 1'b0;
		write_clock(CLK_W'(48_000_000));
		send_random(20);
		drain();
	endtask

	// The result side holds ready low in random bursts, so the output register is
	// sometimes made to wait and sometimes read at once.
	initial begin : result_ready
		int unsigned hold;
		hold = 0;
		out_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold != 0) begin
				hold--;
				out_ch.ready <= 1'b0;
			end else if (idle_on && $urandom_range(0, 5) == 0) begin
				hold = $urandom_range(0, 9);
				out_ch.ready <= 1'b0;
			end else begin
				out_ch.ready <= 1'b1;
			end
		end
	end

	// Each result transaction is compared with the oldest prediction, field by field.
	always @(posedge clk) begin : check_results
		divisor_t want;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			if (pending_divisors.size() == 0) begin
				report_mismatch($sformatf("result with nothing pending: scale %0d step %0d error %0d",
					out_ch.best_scale, out_ch.best_step, out_ch.rate_error));
			end else begin
				want = pending_divisors.pop_front();
				if (out_ch.best_scale !== want.scale)
					report_mismatch($sformatf("best_scale %0d, predicted %0d",
						out_ch.best_scale, want.scale));
				if (out_ch.best_step !== want.step)
					report_mismatch($sformatf("best_step %0d, predicted %0d",
						out_ch.best_step, want.step));
				if (out_ch.rate_error !== want.err)
					report_mismatch($sformatf("rate_error %0d, predicted %0d",
						out_ch.rate_error, want.err));
			end
		end
	end

	// Watchdog: a hung handshake ends the run here.
	initial begin : watchdog
		int unsigned cycle_count;
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("baud_scale_step_search regression: fail");
		$finish;
	end

	initial begin
		arst_n = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_wr_data = '0;
		in_ch.valid = 1'b0;
		in_ch.requested_baud = '0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_reset_clock();
		test_clock_zero();
		test_clock_one();
		test_clock_max();
		test_random_clocks();
		test_no_idle();

		repeat (TAIL_CYCLES) @(posedge clk);
		if (pending_divisors.size() != 0)
			report_mismatch($sformatf("%0d results never arrived", pending_divisors.size()));
		if (mismatches == 0)
			$display("baud_scale_step_search regression: pass");
		else
			$display("baud_scale_step_search regression: fail");
		$finish;
	end

endmodule
